// File: design/giw_pkg.sv
// shared types, constants and the case-selection function for the interpolation weight block
package giw_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int PIXEL_BITS = 8;
  localparam int THR_W      = 8;
  localparam int OUT_W      = 17;
  localparam logic [THR_W-1:0] THR_RESET = 8'd8;

  localparam int SQ_W  = FRAC_BITS + 1;
  localparam int D_W   = FRAC_BITS + 2;
  localparam int P_W   = FRAC_BITS + 3;
  localparam int T_W   = FRAC_BITS + 4;
  localparam int SUM_W = FRAC_BITS + 6;
  localparam int Q_W   = FRAC_BITS + 1;

  typedef logic [PIXEL_BITS-1:0] pix_t;
  typedef logic [D_W-1:0]        dist_t;
  typedef logic [P_W-1:0]        pair_t;
  typedef logic [T_W-1:0]        wgt_t;
  typedef logic [SUM_W-1:0]      sum_t;
  typedef logic [Q_W-1:0]        quot_t;

  typedef enum logic [2:0] {
    CASE_CORNER_TL = 3'd0,
    CASE_CORNER_TR = 3'd1,
    CASE_CORNER_BL = 3'd2,
    CASE_CORNER_BR = 3'd3,
    CASE_HSPLIT    = 3'd4,
    CASE_VSPLIT    = 3'd5,
    CASE_BLEND     = 3'd6
  } case_code_t;

  typedef struct packed {
    logic       valid;
    case_code_t case_code;
    logic       corner_in;
    logic       y_low;
    logic       x_low;
  } ctl_t;

  typedef struct packed {
    logic       valid;
    case_code_t case_code;
    logic       zero;
  } meta_t;

  function automatic case_code_t pick_case(input pix_t p0, input pix_t p1, input pix_t p2,
                                           input pix_t p3, input logic [THR_W-1:0] thr);
    localparam int CW = (PIXEL_BITS > THR_W) ? PIXEL_BITS : THR_W;
    pix_t       v [4];
    logic [1:0] n [4];
    pix_t       tv;
    logic [1:0] tn;
    pix_t       best;
    pix_t       dj;
    logic [1:0] k;
    logic [1:0] pa [5];
    logic [1:0] pb [5];
    case_code_t res;
    pa = '{2'd0, 2'd1, 2'd0, 2'd2, 2'd1};
    pb = '{2'd2, 2'd3, 2'd1, 2'd3, 2'd2};
    v = '{p0, p1, p2, p3};
    n = '{2'd0, 2'd1, 2'd2, 2'd3};
    for (int i = 0; i < 5; i++) begin
      if (v[pa[i]] > v[pb[i]]) begin
        tv = v[pa[i]];
        tn = n[pa[i]];
        v[pa[i]] = v[pb[i]];
        n[pa[i]] = n[pb[i]];
        v[pb[i]] = tv;
        n[pb[i]] = tn;
      end
    end
    best = v[1] - v[0];
    k = 2'd0;
    for (int i = 1; i < 3; i++) begin
      dj = v[i+1] - v[i];
      if (dj > best) begin
        best = dj;
        k = 2'(i);
      end
    end
    if (CW'(best) < CW'(thr)) begin
      res = CASE_BLEND;
    end else if (k == 2'd0) begin
      res = case_code_t'({1'b0, n[0]});
    end else if (k == 2'd2) begin
      res = case_code_t'({1'b0, n[3]});
    end else if ((n[0] == 2'd0 && n[1] == 2'd1) || (n[0] == 2'd2 && n[1] == 2'd3)) begin
      res = CASE_HSPLIT;
    end else if ((n[0] == 2'd0 && n[1] == 2'd2) || (n[0] == 2'd1 && n[1] == 2'd3)) begin
      res = CASE_VSPLIT;
    end else begin
      res = CASE_BLEND;
    end
    return res;
  endfunction

endpackage

// File: design/giw_front.sv
// front pipeline: case choice, corner distances, products, weight selection and sum
module giw_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  giw_pkg::pix_t             pix_tl,
  input  giw_pkg::pix_t             pix_tr,
  input  giw_pkg::pix_t             pix_bl,
  input  giw_pkg::pix_t             pix_br,
  input  logic [15:0]               offset_x,
  input  logic [15:0]               offset_y,
  input  logic [giw_pkg::THR_W-1:0] thr,
  output giw_pkg::wgt_t             w_o [4],
  output giw_pkg::sum_t             sum_o,
  output giw_pkg::ctl_t             ctl_o
);

  localparam int F  = giw_pkg::FRAC_BITS;
  localparam int DW = giw_pkg::D_W;
  localparam int PW = giw_pkg::P_W;
  localparam int TW = giw_pkg::T_W;
  localparam int SW = giw_pkg::SUM_W;
  localparam logic [F:0] ONE   = (F+1)'(1) << F;
  localparam logic [F:0] HALF  = (F+1)'(1) << (F-1);
  localparam logic [F:0] HALF3 = HALF + (HALF << 1);
  localparam int PA [6] = '{0, 0, 0, 1, 1, 2};
  localparam int PB [6] = '{1, 2, 3, 2, 3, 3};

  logic [F-1:0]     x, y;
  logic [F:0]       ix, iy, xy;
  logic [2*F+1:0]   prod_xx, prod_yy, prod_ix, prod_iy;
  logic             corner_hit;
  giw_pkg::ctl_t    ctl_a_nxt;

  giw_pkg::ctl_t    ctl_a_r, ctl_b_r, ctl_c_r, ctl_d_r, ctl_e_r;
  logic [F:0]       sq_a_r [4];
  giw_pkg::dist_t   d_b_r [4];
  giw_pkg::dist_t   d_c_r [4];
  giw_pkg::pair_t   p_c_r [6];
  giw_pkg::pair_t   p_d_r [6];
  giw_pkg::wgt_t    t_d_r [4];
  giw_pkg::dist_t   d_d_r [4];
  giw_pkg::wgt_t    w_e_r [4];
  giw_pkg::sum_t    sum_e_r;
  giw_pkg::wgt_t    w_nxt [4];
  giw_pkg::sum_t    sum_nxt;
  logic [2*DW-1:0]  pp [6];
  logic [PW+DW-1:0] tp [4];

  // stage a: squares, case choice and triangle tests
  always_comb begin
    x = F'(offset_x);
    y = F'(offset_y);
    ix = ONE - {1'b0, x};
    iy = ONE - {1'b0, y};
    xy = {1'b0, x} + {1'b0, y};
    prod_xx = {1'b0, x} * {1'b0, x};
    prod_yy = {1'b0, y} * {1'b0, y};
    prod_ix = ix * ix;
    prod_iy = iy * iy;
    ctl_a_nxt.valid = start;
    ctl_a_nxt.case_code = giw_pkg::pick_case(pix_tl, pix_tr, pix_bl, pix_br, thr);
    case (ctl_a_nxt.case_code)
      giw_pkg::CASE_CORNER_TL, giw_pkg::CASE_CORNER_TR: corner_hit = xy < HALF;
      giw_pkg::CASE_CORNER_BL: corner_hit = {1'b0, y} > ({1'b0, x} + HALF);
      giw_pkg::CASE_CORNER_BR: corner_hit = xy > HALF3;
      default: corner_hit = 1'b0;
    endcase
    ctl_a_nxt.corner_in = corner_hit;
    ctl_a_nxt.y_low = {1'b0, y} < HALF;
    ctl_a_nxt.x_low = {1'b0, x} < HALF;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
      ctl_b_r <= '0;
      ctl_c_r <= '0;
      ctl_d_r <= '0;
      ctl_e_r <= '0;
    end else begin
      ctl_a_r <= ctl_a_nxt;
      ctl_b_r <= ctl_a_r;
      ctl_c_r <= ctl_b_r;
      ctl_d_r <= ctl_c_r;
      ctl_e_r <= ctl_d_r;
    end
  end

  // squares: xx, yy, (1-x)^2, (1-y)^2
  always_ff @(posedge clk) begin
    sq_a_r[0] <= prod_xx[2*F:F];
    sq_a_r[1] <= prod_yy[2*F:F];
    sq_a_r[2] <= prod_ix[2*F:F];
    sq_a_r[3] <= prod_iy[2*F:F];
  end

  // stage b: squared distances
  always_ff @(posedge clk) begin
    d_b_r[0] <= DW'(sq_a_r[0]) + DW'(sq_a_r[1]);
    d_b_r[1] <= DW'(sq_a_r[2]) + DW'(sq_a_r[1]);
    d_b_r[2] <= DW'(sq_a_r[0]) + DW'(sq_a_r[3]);
    d_b_r[3] <= DW'(sq_a_r[2]) + DW'(sq_a_r[3]);
  end

  // stage c: pair products
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      pp[i] = d_b_r[PA[i]] * d_b_r[PB[i]];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 6; i++) begin
      p_c_r[i] <= pp[i][F+PW-1:F];
    end
    d_c_r <= d_b_r;
  end

  // stage d: triple products for full blend
  always_comb begin
    tp[0] = p_c_r[3] * d_c_r[3];
    tp[1] = p_c_r[1] * d_c_r[3];
    tp[2] = p_c_r[0] * d_c_r[3];
    tp[3] = p_c_r[0] * d_c_r[2];
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      t_d_r[i] <= tp[i][F+TW-1:F];
    end
    p_d_r <= p_c_r;
    d_d_r <= d_c_r;
  end

  // stage e: weight selection and sum
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      w_nxt[i] = '0;
    end
    case (ctl_d_r.case_code)
      giw_pkg::CASE_CORNER_TL: begin
        if (ctl_d_r.corner_in) begin
          w_nxt[0] = TW'(ONE);
        end else begin
          w_nxt[1] = TW'(p_d_r[5]);
          w_nxt[2] = TW'(p_d_r[4]);
          w_nxt[3] = TW'(p_d_r[3]);
        end
      end
      giw_pkg::CASE_CORNER_TR: begin
        if (ctl_d_r.corner_in) begin
          w_nxt[1] = TW'(ONE);
        end else begin
          w_nxt[0] = TW'(p_d_r[5]);
          w_nxt[2] = TW'(p_d_r[2]);
          w_nxt[3] = TW'(p_d_r[1]);
        end
      end
      giw_pkg::CASE_CORNER_BL: begin
        if (ctl_d_r.corner_in) begin
          w_nxt[2] = TW'(ONE);
        end else begin
          w_nxt[0] = TW'(p_d_r[4]);
          w_nxt[1] = TW'(p_d_r[2]);
          w_nxt[3] = TW'(p_d_r[0]);
        end
      end
      giw_pkg::CASE_CORNER_BR: begin
        if (ctl_d_r.corner_in) begin
          w_nxt[3] = TW'(ONE);
        end else begin
          w_nxt[0] = TW'(p_d_r[3]);
          w_nxt[1] = TW'(p_d_r[1]);
          w_nxt[2] = TW'(p_d_r[0]);
        end
      end
      giw_pkg::CASE_HSPLIT: begin
        if (ctl_d_r.y_low) begin
          w_nxt[0] = TW'(d_d_r[1]);
          w_nxt[1] = TW'(d_d_r[0]);
        end else begin
          w_nxt[2] = TW'(d_d_r[3]);
          w_nxt[3] = TW'(d_d_r[2]);
        end
      end
      giw_pkg::CASE_VSPLIT: begin
        if (ctl_d_r.x_low) begin
          w_nxt[0] = TW'(d_d_r[2]);
          w_nxt[2] = TW'(d_d_r[0]);
        end else begin
          w_nxt[1] = TW'(d_d_r[3]);
          w_nxt[3] = TW'(d_d_r[1]);
        end
      end
      default: begin
        w_nxt = t_d_r;
      end
    endcase
    sum_nxt = SW'(w_nxt[0]) + SW'(w_nxt[1]) + SW'(w_nxt[2]) + SW'(w_nxt[3]);
  end

  always_ff @(posedge clk) begin
    w_e_r   <= w_nxt;
    sum_e_r <= sum_nxt;
  end

  assign w_o   = w_e_r;
  assign sum_o = sum_e_r;
  assign ctl_o = ctl_e_r;

endmodule

// File: design/giw_div_lane.sv
// one normalization lane: pipelined restoring division of weight times one by the sum
module giw_div_lane (
  input  logic          clk,
  input  giw_pkg::wgt_t w_i,
  input  giw_pkg::sum_t sum_i,
  output giw_pkg::quot_t q_o
);

  localparam int F  = giw_pkg::FRAC_BITS;
  localparam int SW = giw_pkg::SUM_W;
  localparam int QW = giw_pkg::Q_W;

  logic [SW-1:0] r_r [F+1];
  logic [SW-1:0] s_r [F+1];
  logic [QW-1:0] q_r [F+1];
  logic [SW-1:0] r0_nxt;
  logic          ge0;

  // first stage: integer quotient bit
  always_comb begin
    ge0 = SW'(w_i) >= sum_i;
    r0_nxt = ge0 ? (SW'(w_i) - sum_i) : SW'(w_i);
  end

  always_ff @(posedge clk) begin
    r_r[0] <= r0_nxt;
    s_r[0] <= sum_i;
    q_r[0] <= QW'(ge0);
  end

  // one fraction bit per stage
  for (genvar i = 1; i <= F; i++) begin : g_stage
    logic [SW:0] r_sh;
    logic        ge;
    always_comb begin
      r_sh = {r_r[i-1], 1'b0};
      ge = r_sh >= {1'b0, s_r[i-1]};
    end
    always_ff @(posedge clk) begin
      r_r[i] <= ge ? SW'(r_sh - {1'b0, s_r[i-1]}) : SW'(r_sh);
      s_r[i] <= s_r[i-1];
      q_r[i] <= {q_r[i-1][QW-2:0], ge};
    end
  end

  assign q_o = q_r[F];

endmodule

// File: design/giw_merge.sv
// merge stage: gathers the lane quotients, forces zero weights and drives the result registers
module giw_merge (
  input  logic                     clk,
  input  logic                     rst_n,
  input  giw_pkg::quot_t           q_i [4],
  input  giw_pkg::meta_t           meta_i,
  output logic                     out_valid,
  output logic [giw_pkg::OUT_W-1:0] w_o [4],
  output logic [2:0]               case_code_o,
  output logic                     sum_zero_o
);

  localparam int OW = giw_pkg::OUT_W;

  logic          valid_r;
  logic [OW-1:0] w_r [4];
  logic [2:0]    case_r;
  logic          zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= meta_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      w_r[i] <= meta_i.zero ? '0 : OW'(q_i[i]);
    end
    case_r <= meta_i.case_code;
    zero_r <= meta_i.zero;
  end

  assign out_valid   = valid_r;
  assign w_o         = w_r;
  assign case_code_o = case_r;
  assign sum_zero_o  = zero_r;

endmodule

// File: design/gravity_interp_weights_top.sv
// top level of the gravity interpolation weight block
//
//  channel  ports                      handshake
//  request  start, busy, in_*          taken when start and not busy
//  result   out_valid, out_*           one-cycle strobe, no back-pressure
//  config   cfg_valid, cfg_ready, cfg_data   written when valid and ready
//
// one request per cycle; busy and cfg_ready are constant, nothing stalls
// a result is registered in the four front stages, the weight stage,
// the divider lanes and the output register
// reset is synchronous, clears the pipeline valids and sets the threshold to 8
// the receiver cannot stall; every strobe carries a result
module gravity_interp_weights_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_pixel_top_left,
  input  logic [7:0]  in_pixel_top_right,
  input  logic [7:0]  in_pixel_bottom_left,
  input  logic [7:0]  in_pixel_bottom_right,
  input  logic [15:0] in_offset_x,
  input  logic [15:0] in_offset_y,
  output logic        out_valid,
  output logic [16:0] out_weight_top_left,
  output logic [16:0] out_weight_top_right,
  output logic [16:0] out_weight_bottom_left,
  output logic [16:0] out_weight_bottom_right,
  output logic [2:0]  out_case_code,
  output logic        out_sum_zero,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  localparam int F = giw_pkg::FRAC_BITS;

  logic [giw_pkg::THR_W-1:0] thr_r;
  giw_pkg::wgt_t             w_f [4];
  giw_pkg::sum_t             sum_f;
  giw_pkg::ctl_t             ctl_f;
  giw_pkg::quot_t            q_l [4];
  giw_pkg::meta_t            meta_r [F+1];
  logic [giw_pkg::OUT_W-1:0] w_out [4];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= giw_pkg::THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thr_r <= cfg_data;
    end
  end

  giw_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start && !busy),
    .pix_tl   (giw_pkg::pix_t'(in_pixel_top_left)),
    .pix_tr   (giw_pkg::pix_t'(in_pixel_top_right)),
    .pix_bl   (giw_pkg::pix_t'(in_pixel_bottom_left)),
    .pix_br   (giw_pkg::pix_t'(in_pixel_bottom_right)),
    .offset_x (in_offset_x),
    .offset_y (in_offset_y),
    .thr      (thr_r),
    .w_o      (w_f),
    .sum_o    (sum_f),
    .ctl_o    (ctl_f)
  );

  for (genvar i = 0; i < 4; i++) begin : g_lane
    giw_div_lane u_lane (
      .clk   (clk),
      .w_i   (w_f[i]),
      .sum_i (sum_f),
      .q_o   (q_l[i])
    );
  end

  // request info travelling alongside the divider lanes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= F; i++) begin
        meta_r[i] <= '0;
      end
    end else begin
      meta_r[0].valid     <= ctl_f.valid;
      meta_r[0].case_code <= ctl_f.case_code;
      meta_r[0].zero      <= (sum_f == '0);
      for (int i = 1; i <= F; i++) begin
        meta_r[i] <= meta_r[i-1];
      end
    end
  end

  giw_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_i         (q_l),
    .meta_i      (meta_r[F]),
    .out_valid   (out_valid),
    .w_o         (w_out),
    .case_code_o (out_case_code),
    .sum_zero_o  (out_sum_zero)
  );

  assign out_weight_top_left     = w_out[0];
  assign out_weight_top_right    = w_out[1];
  assign out_weight_bottom_left  = w_out[2];
  assign out_weight_bottom_right = w_out[3];

endmodule
